@@ src/angle_kalman_filter_unit_assert.svh @@
`ifndef ANGLE_KALMAN_FILTER_UNIT_ASSERT_SVH
`define ANGLE_KALMAN_FILTER_UNIT_ASSERT_SVH

// implication checked every cycle outside reset
`define AKF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define AKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked also across reset
`define AKF_ASSERT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/akf_pkg.sv @@
`timescale 1ns / 1ps
package akf_pkg;

  typedef enum logic [1:0] {
    SH14,
    SH16,
    SH30
  } shift_t;

  typedef struct packed {
    logic   start;
    shift_t sh;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG,
    ST_T1,
    ST_P00,
    ST_QB,
    ST_K0,
    ST_K1,
    ST_UA,
    ST_UB,
    ST_C10,
    ST_C11,
    ST_C00,
    ST_C01,
    ST_DONE
  } state_t;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic [31:0] ANGLE_NOISE_RST = 32'd1073742;
  localparam logic [31:0] BIAS_NOISE_RST  = 32'd3221225;
  localparam logic [31:0] MEAS_NOISE_RST  = 32'd32212255;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
    if (v > 53'sh7fff_ffff_ffff) begin
      return 48'sh7fff_ffff_ffff;
    end else if (v < -53'sh8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end else begin
      return $signed(v[47:0]);
    end
  endfunction

endpackage

@@ src/akf_mul.sv @@
`timescale 1ns / 1ps
module akf_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  akf_pkg::mul_req_t    req,
  input  logic signed [31:0]   a,
  input  logic signed [47:0]   b,
  output logic                 done,
  output logic signed [50:0]   res
);

  logic [31:0] a_mag;
  logic [47:0] b_mag;
  logic [31:0] ua;
  logic [47:0] ub;
  logic [47:0] hi;
  logic [31:0] lo;
  logic        neg;
  logic        busy;
  logic [5:0]  cnt;
  akf_pkg::shift_t sh;
  logic [48:0] psum;
  logic [79:0] prod;
  logic [50:0] rmag;

  assign a_mag = a[31] ? 32'(-a) : 32'(a);
  assign b_mag = b[47] ? 48'(-b) : 48'(b);
  assign psum  = {1'b0, hi} + (ua[0] ? {1'b0, ub} : 49'd0);
  assign prod  = {hi, lo};

  // round half away from zero on the magnitude
  always_comb begin
    case (sh)
      akf_pkg::SH14: rmag = {1'b0, prod[63:14]} + 51'(prod[13]);
      akf_pkg::SH30: rmag = {1'b0, prod[79:30]} + 51'(prod[29]);
      default:       rmag = {1'b0, prod[65:16]} + 51'(prod[15]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ua   <= a_mag;
        ub   <= b_mag;
        hi   <= '0;
        lo   <= '0;
        neg  <= a[31] ^ b[47];
        sh   <= req.sh;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == 6'd32) begin
          res  <= neg ? -$signed(rmag) : $signed(rmag);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          hi  <= psum[48:1];
          lo  <= {psum[0], lo[31:1]};
          ua  <= ua >> 1;
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

endmodule

@@ src/akf_div.sv @@
`timescale 1ns / 1ps
module akf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [47:0]   p,
  input  logic signed [48:0]   s,
  output logic                 done,
  output logic signed [31:0]   k
);

  logic [47:0] up;
  logic [47:0] us;
  logic [47:0] rem;
  logic [30:0] q;
  logic        neg;
  logic        busy;
  logic [4:0]  cnt;
  logic [48:0] r2;
  logic [31:0] qx;

  assign r2 = {rem, 1'b0};
  assign qx = {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        up   <= p[47] ? 48'(-p) : 48'(p);
        us   <= s[47:0];
        neg  <= p[47];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == 5'd0) begin
          // gain of two or more saturates
          if ({1'b0, up} >= {us, 1'b0}) begin
            k    <= neg ? 32'sh80000000 : 32'sh7fffffff;
            done <= 1'b1;
            busy <= 1'b0;
          end else begin
            if (up >= us) begin
              q   <= 31'd1;
              rem <= up - us;
            end else begin
              q   <= 31'd0;
              rem <= up;
            end
            cnt <= 5'd1;
          end
        end else if (cnt == 5'd31) begin
          k    <= neg ? -$signed(qx) : $signed(qx);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (r2 >= {1'b0, us}) begin
            rem <= 48'(r2 - {1'b0, us});
            q   <= {q[29:0], 1'b1};
          end else begin
            rem <= r2[47:0];
            q   <= {q[29:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

endmodule

@@ src/angle_kalman_filter_unit.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   func, meas_angle, gyro_rate, time_step
// out       source     out_valid / out_stall angle_estimate, unbiased_rate, bias_estimate
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// an update beat is ten products on one shift-add
// multiplier of 32 steps each, plus up to two restoring divisions of at most 31 steps for the gains
// a load beat goes from idle straight to the done state
// reset clears angle, bias, rate, covariance and loads the default noise values
// a finished result waits in the output register while the next beat is taken;
// the sequencer only holds in its last step when that register is still full
module angle_kalman_filter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] meas_angle,
  input  logic signed [31:0] gyro_rate,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] unbiased_rate,
  output logic signed [31:0] bias_estimate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  akf_pkg::state_t state, state_next;

  logic [31:0] qa, qb, qr;
  logic signed [31:0] angle, bias, rate, meas, y, k0, k1;
  logic [15:0] dt;
  logic signed [47:0] p00, p01, p10, p11, inner;
  logic signed [48:0] t1, s;
  logic issued;
  logic s_pos;

  akf_pkg::mul_req_t  mreq;
  logic signed [31:0] mul_a;
  logic signed [47:0] mul_b;
  logic               mul_done;
  logic signed [50:0] mul_res;

  logic               div_start;
  logic signed [47:0] div_p;
  logic               div_done;
  logic signed [31:0] div_k;

  logic signed [31:0] dt_s;
  logic signed [52:0] qa_ext;
  logic signed [48:0] qr_ext;

  assign cfg_ready = 1'b1;
  assign s_pos  = !s[48] && (s != '0);
  assign dt_s   = $signed({16'd0, dt});
  assign qa_ext = $signed({19'd0, qa, 2'b00});
  assign qr_ext = $signed({15'd0, qr, 2'b00});

  akf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  akf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .p     (div_p),
    .s     (s),
    .done  (div_done),
    .k     (div_k)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      akf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = func ? akf_pkg::ST_DONE : akf_pkg::ST_ANG;
        end
      end
      akf_pkg::ST_ANG: if (mul_done) state_next = akf_pkg::ST_T1;
      akf_pkg::ST_T1:  if (mul_done) state_next = akf_pkg::ST_P00;
      akf_pkg::ST_P00: if (mul_done) state_next = akf_pkg::ST_QB;
      akf_pkg::ST_QB:  if (mul_done) state_next = akf_pkg::ST_K0;
      akf_pkg::ST_K0:  if (!s_pos || div_done) state_next = akf_pkg::ST_K1;
      akf_pkg::ST_K1:  if (!s_pos || div_done) state_next = akf_pkg::ST_UA;
      akf_pkg::ST_UA:  if (mul_done) state_next = akf_pkg::ST_UB;
      akf_pkg::ST_UB:  if (mul_done) state_next = akf_pkg::ST_C10;
      akf_pkg::ST_C10: if (mul_done) state_next = akf_pkg::ST_C11;
      akf_pkg::ST_C11: if (mul_done) state_next = akf_pkg::ST_C00;
      akf_pkg::ST_C00: if (mul_done) state_next = akf_pkg::ST_C01;
      akf_pkg::ST_C01: if (mul_done) state_next = akf_pkg::ST_DONE;
      akf_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = akf_pkg::ST_IDLE;
      end
      default: state_next = akf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != akf_pkg::ST_IDLE);
    mreq.start = 1'b0;
    mreq.sh    = akf_pkg::SH16;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_p      = p00;
    unique case (state)
      akf_pkg::ST_ANG: begin
        mul_a = dt_s;
        mul_b = 48'(rate);
      end
      akf_pkg::ST_T1: begin
        mul_a = dt_s;
        mul_b = p11;
      end
      akf_pkg::ST_P00: begin
        mul_a = dt_s;
        mul_b = inner;
      end
      akf_pkg::ST_QB: begin
        mul_a   = dt_s;
        mul_b   = $signed({16'd0, qb});
        mreq.sh = akf_pkg::SH14;
      end
      akf_pkg::ST_K0: begin
        div_p     = p00;
        div_start = s_pos && !issued;
      end
      akf_pkg::ST_K1: begin
        div_p     = p10;
        div_start = s_pos && !issued;
      end
      akf_pkg::ST_UA: begin
        mul_a   = k0;
        mul_b   = 48'(y);
        mreq.sh = akf_pkg::SH30;
      end
      akf_pkg::ST_UB: begin
        mul_a   = k1;
        mul_b   = 48'(y);
        mreq.sh = akf_pkg::SH30;
      end
      akf_pkg::ST_C10: begin
        mul_a   = k1;
        mul_b   = p00;
        mreq.sh = akf_pkg::SH30;
      end
      akf_pkg::ST_C11: begin
        mul_a   = k1;
        mul_b   = p01;
        mreq.sh = akf_pkg::SH30;
      end
      akf_pkg::ST_C00: begin
        mul_a   = k0;
        mul_b   = p00;
        mreq.sh = akf_pkg::SH30;
      end
      akf_pkg::ST_C01: begin
        mul_a   = k0;
        mul_b   = p01;
        mreq.sh = akf_pkg::SH30;
      end
      default: begin
      end
    endcase
    case (state)
      akf_pkg::ST_ANG, akf_pkg::ST_T1, akf_pkg::ST_P00, akf_pkg::ST_QB,
      akf_pkg::ST_UA, akf_pkg::ST_UB, akf_pkg::ST_C10, akf_pkg::ST_C11,
      akf_pkg::ST_C00, akf_pkg::ST_C01: mreq.start = !issued;
      default: mreq.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= akf_pkg::ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      qa        <= akf_pkg::ANGLE_NOISE_RST;
      qb        <= akf_pkg::BIAS_NOISE_RST;
      qr        <= akf_pkg::MEAS_NOISE_RST;
      angle     <= '0;
      bias      <= '0;
      rate      <= '0;
      p00       <= '0;
      p01       <= '0;
      p10       <= '0;
      p11       <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          akf_pkg::REG_ANGLE_NOISE: qa <= cfg_data;
          akf_pkg::REG_BIAS_NOISE:  qb <= cfg_data;
          akf_pkg::REG_MEAS_NOISE:  qr <= cfg_data;
          default: begin
          end
        endcase
      end

      if (mreq.start || div_start) begin
        issued <= 1'b1;
      end else if (mul_done || div_done) begin
        issued <= 1'b0;
      end

      if (state == akf_pkg::ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        akf_pkg::ST_IDLE: begin
          if (in_valid) begin
            meas <= meas_angle;
            dt   <= time_step;
            if (func) begin
              angle <= meas_angle;
            end else begin
              rate <= akf_pkg::sat32(53'(gyro_rate) - 53'(bias));
            end
          end
        end
        akf_pkg::ST_ANG: begin
          if (mul_done) angle <= akf_pkg::sat32(53'(angle) + 53'(mul_res));
        end
        akf_pkg::ST_T1: begin
          if (mul_done) begin
            t1    <= mul_res[48:0];
            inner <= akf_pkg::sat48(53'(mul_res) - 53'(p01) - 53'(p10) + qa_ext);
          end
        end
        akf_pkg::ST_P00: begin
          if (mul_done) begin
            p00 <= akf_pkg::sat48(53'(p00) + 53'(mul_res));
            p01 <= akf_pkg::sat48(53'(p01) - 53'(t1));
            p10 <= akf_pkg::sat48(53'(p10) - 53'(t1));
          end
        end
        akf_pkg::ST_QB: begin
          if (mul_done) begin
            p11 <= akf_pkg::sat48(53'(p11) + 53'(mul_res));
            y   <= akf_pkg::sat32(53'(meas) - 53'(angle));
            s   <= 49'(p00) + qr_ext;
          end
        end
        akf_pkg::ST_K0: begin
          if (!s_pos) k0 <= '0;
          else if (div_done) k0 <= div_k;
        end
        akf_pkg::ST_K1: begin
          if (!s_pos) k1 <= '0;
          else if (div_done) k1 <= div_k;
        end
        akf_pkg::ST_UA: begin
          if (mul_done) angle <= akf_pkg::sat32(53'(angle) + 53'(mul_res));
        end
        akf_pkg::ST_UB: begin
          if (mul_done) bias <= akf_pkg::sat32(53'(bias) + 53'(mul_res));
        end
        akf_pkg::ST_C10: begin
          if (mul_done) p10 <= akf_pkg::sat48(53'(p10) - 53'(mul_res));
        end
        akf_pkg::ST_C11: begin
          if (mul_done) p11 <= akf_pkg::sat48(53'(p11) - 53'(mul_res));
        end
        akf_pkg::ST_C00: begin
          if (mul_done) p00 <= akf_pkg::sat48(53'(p00) - 53'(mul_res));
        end
        akf_pkg::ST_C01: begin
          if (mul_done) p01 <= akf_pkg::sat48(53'(p01) - 53'(mul_res));
        end
        akf_pkg::ST_DONE: begin
          if (!out_valid || !out_stall) begin
            angle_estimate <= angle;
            unbiased_rate  <= rate;
            bias_estimate  <= bias;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/akf_checker.sv @@
`timescale 1ns / 1ps
`include "angle_kalman_filter_unit_assert.svh"
module akf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               func,
  input logic signed [31:0] meas_angle,
  input logic signed [31:0] gyro_rate,
  input logic [15:0]        time_step,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] angle_estimate,
  input logic signed [31:0] unbiased_rate,
  input logic signed [31:0] bias_estimate,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  `AKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(angle_estimate), "stalled out beat dropped or changed")
  `AKF_ASSERT_ANY(a_rst_clear, $past(rst), !out_valid, "out beat present after reset")
  `AKF_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "in beat taken without going busy")
  `AKF_ASSERT_SAME(a_out_from_busy, $rose(out_valid), $past(in_stall), "result shown without a beat in work")

endmodule

bind angle_kalman_filter_unit akf_checker u_akf_checker (.*);

@@ bench/tb_angle_kalman_filter_unit.sv @@
`timescale 1ns / 1ps
module tb_angle_kalman_filter_unit;

  localparam int     LIMIT_CYCLES = 6000000;
  localparam longint Q_ONE        = 64'sd65536;

  typedef struct {
    logic               func;
    logic signed [31:0] meas;
    logic signed [31:0] gyro;
    logic [15:0]        dt;
  } imu_beat_t;

  typedef struct {
    logic [31:0] ang;
    logic [31:0] rate;
    logic [31:0] bias;
  } est_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic signed [31:0] meas_angle = '0;
  logic signed [31:0] gyro_rate = '0;
  logic [15:0]        time_step = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] unbiased_rate;
  logic signed [31:0] bias_estimate;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  imu_beat_t pending_q[$];
  est_beat_t est_q[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_loads = 0;
  int        n_cfg = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        in_took = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  longint      ang_st, bias_st, rate_st;
  longint      cov[4];
  logic [31:0] nz_ang, nz_bias, nz_meas;

  angle_kalman_filter_unit u_top (.*);

  always #4 clk = ~clk;

  function automatic longint clampv(longint v, int bits);
    longint lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [63:0] magn(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  function automatic longint mul_round(longint a, longint b, int n);
    bit          neg;
    logic [63:0] ua, ub, hi, lo, h, l, t, c, r;
    neg = (a < 0) != (b < 0);
    ua = magn(a);
    ub = magn(b);
    c = 0;
    r = 0;
    if (ua > 64'hFFFF_FFFF) ua = 64'hFFFF_FFFF;
    if (ub > 64'hFFFF_FFFF_FFFF) ub = 64'hFFFF_FFFF_FFFF;
    hi = ub >> 16;
    lo = ub & 64'hFFFF;
    h = ua * hi;
    l = ua * lo;
    if (n == 16) r = 64'h8000;
    else c = 64'd1 << (n - 17);
    t = h + (l >> 16) + c + (((l & 64'hFFFF) + r) >> 16);
    t = t >> (n - 16);
    if (t > (64'd1 << 62)) t = 64'd1 << 62;
    return neg ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint gain_q30(longint p, longint s);
    logic [63:0] up, us, ip, rem, q;
    up = magn(p);
    us = 64'(s);
    if (up > 64'hFFFF_FFFF_FFFF) up = 64'hFFFF_FFFF_FFFF;
    ip = up / us;
    if (ip >= 2) return p < 0 ? -(64'sd1 <<< 31) : (64'sd1 <<< 31) - 1;
    rem = up % us;
    q = ip;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= us) begin
        rem = rem - us;
        q = q | 64'd1;
      end
    end
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_beat(logic f, logic signed [31:0] m, logic signed [31:0] g,
                              logic [15:0] dt);
    longint      d, t1, inner, y, s, k0, k1, p00, p01;
    logic [63:0] qb, bn;
    est_beat_t   e;
    k0 = 0;
    k1 = 0;
    if (f) begin
      ang_st = longint'(m);
    end else begin
      d = longint'({48'd0, dt});
      rate_st = clampv(longint'(g) - bias_st, 32);
      ang_st = clampv(ang_st + mul_round(d, rate_st, 16), 32);
      t1 = mul_round(d, cov[3], 16);
      inner = clampv(t1 - cov[1] - cov[2] + (longint'({32'd0, nz_ang}) <<< 2), 48);
      cov[0] = clampv(cov[0] + mul_round(d, inner, 16), 48);
      cov[1] = clampv(cov[1] - t1, 48);
      cov[2] = clampv(cov[2] - t1, 48);
      bn = {32'd0, nz_bias};
      qb = (bn * {48'd0, dt} + 64'h2000) >> 14;
      cov[3] = clampv(cov[3] + longint'(qb), 48);
      y = clampv(longint'(m) - ang_st, 32);
      s = cov[0] + (longint'({32'd0, nz_meas}) <<< 2);
      if (s > 0) begin
        k0 = gain_q30(cov[0], s);
        k1 = gain_q30(cov[2], s);
      end
      ang_st = clampv(ang_st + mul_round(k0, y, 30), 32);
      bias_st = clampv(bias_st + mul_round(k1, y, 30), 32);
      p00 = cov[0];
      p01 = cov[1];
      cov[0] = clampv(p00 - mul_round(k0, p00, 30), 48);
      cov[1] = clampv(p01 - mul_round(k0, p01, 30), 48);
      cov[2] = clampv(cov[2] - mul_round(k1, p00, 30), 48);
      cov[3] = clampv(cov[3] - mul_round(k1, p01, 30), 48);
    end
    e.ang = ang_st[31:0];
    e.rate = rate_st[31:0];
    e.bias = bias_st[31:0];
    est_q.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycles, got, want);
  endtask

  task automatic push_beat(logic f, logic signed [31:0] m, logic signed [31:0] g,
                           logic [15:0] dt);
    imu_beat_t b;
    b.func = f;
    b.meas = m;
    b.gyro = g;
    b.dt = dt;
    pending_q.push_back(b);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      akf_pkg::REG_ANGLE_NOISE: nz_ang = val;
      akf_pkg::REG_BIAS_NOISE:  nz_bias = val;
      default:                  nz_meas = val;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_q.size() == 0 && !in_valid && est_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_noise(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    drain();
    write_reg(akf_pkg::REG_ANGLE_NOISE, a);
    write_reg(akf_pkg::REG_BIAS_NOISE, b);
    write_reg(akf_pkg::REG_MEAS_NOISE, m);
  endtask

  task automatic random_beats(int n);
    logic signed [31:0] m, g;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        push_beat(1'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom));
      end else begin
        m = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        g = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        push_beat($urandom_range(0, 99) < 5, m, g, 16'($urandom_range(0, 4000)));
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("angle_kalman_filter_unit test failed");
      $finish;
    end
    if (!rst && in_valid && !in_stall) begin
      predict_beat(func, meas_angle, gyro_rate, time_step);
      void'(pending_q.pop_front());
      n_sent++;
      if (func) n_loads++;
      in_took = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (est_q.size() == 0) begin
        report_mismatch("unexpected result", angle_estimate, 'x);
      end else begin
        est_beat_t e;
        e = est_q.pop_front();
        if (angle_estimate !== e.ang) report_mismatch("angle", angle_estimate, e.ang);
        if (unbiased_rate !== e.rate) report_mismatch("rate", unbiased_rate, e.rate);
        if (bias_estimate !== e.bias) report_mismatch("bias", bias_estimate, e.bias);
        n_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_valid <= 1'b1;
        func <= pending_q[0].func;
        meas_angle <= pending_q[0].meas;
        gyro_rate <= pending_q[0].gyro;
        time_step <= pending_q[0].dt;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      out_gap = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    ang_st = 0;
    bias_st = 0;
    rate_st = 0;
    for (int i = 0; i < 4; i++) cov[i] = 0;
    nz_ang = akf_pkg::ANGLE_NOISE_RST;
    nz_bias = akf_pkg::BIAS_NOISE_RST;
    nz_meas = akf_pkg::MEAS_NOISE_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, loads, zero and full time steps
    push_beat(1'b0, 32'sd0, 32'sd0, 16'd0);
    push_beat(1'b1, 32'sh7fffffff, 32'sd0, 16'd0);
    push_beat(1'b0, 32'sh7fffffff, 32'sh7fffffff, 16'hffff);
    push_beat(1'b0, 32'sh80000000, 32'sh80000000, 16'hffff);
    push_beat(1'b1, 32'sh80000000, 32'sh7fffffff, 16'hffff);
    push_beat(1'b0, 32'sh80000000, 32'sh7fffffff, 16'd1);
    push_beat(1'b0, 32'sd0, 32'sd0, 16'hffff);
    push_beat(1'b1, 32'sd0, 32'sd0, 16'd0);
    for (int i = 0; i < 6; i++) push_beat(1'b0, 32'(Q_ONE * 10), 32'(Q_ONE), 16'd655);
    set_noise(32'hffff_ffff, 32'hffff_ffff, 32'd1);
    for (int i = 0; i < 6; i++) push_beat(1'b0, 32'sh7fffffff, 32'sh80000000, 16'hffff);
    push_beat(1'b0, 32'sh80000000, 32'sh7fffffff, 16'hffff);
    set_noise(32'd0, 32'd0, 32'hffff_ffff);
    for (int i = 0; i < 4; i++) push_beat(1'b0, 32'sh40000000, 32'sd0, 16'hffff);

    set_noise(akf_pkg::ANGLE_NOISE_RST, akf_pkg::BIAS_NOISE_RST, akf_pkg::MEAS_NOISE_RST);
    random_beats(350);
    set_noise(32'hffff_ffff, 32'hffff_ffff, 32'd1);
    random_beats(250);
    set_noise(32'd0, 32'd0, 32'hffff_ffff);
    random_beats(250);
    set_noise($urandom, $urandom, $urandom_range(1, 32'hffff_ffff));
    random_beats(250);
    set_noise($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
              $urandom_range(1, 1 << 28));
    random_beats(300);
    drain();
    quiet = 1'b1;
    random_beats(280);
    drain();
    repeat (500) @(posedge clk);

    $display("%0d input beats (%0d loads), %0d results checked, %0d register writes",
             n_sent, n_loads, n_checked, n_cfg);
    if (errors == 0 && est_q.size() == 0) begin
      $display("angle_kalman_filter_unit test passed");
    end else begin
      $display("%0d errors, %0d results missing", errors, est_q.size());
      $display("angle_kalman_filter_unit test failed");
    end
    $finish;
  end

endmodule
